// File: rtl/pgd_pkg.sv
package pgd_pkg;

   localparam int AXIS_W = 7;
   localparam int CSR_IDX_W = 3;
   localparam int Q24 = 16777216;

   localparam logic FUNC_DEPOSIT = 1'b0;
   localparam logic FUNC_READ    = 1'b1;

   localparam logic [CSR_IDX_W-1:0] CSR_GRID_SCALE = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_OFFSET_X   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_OFFSET_Y   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_OFFSET_Z   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_NORM_SCALE = 3'd4;

   localparam logic [31:0] GRID_SCALE_RESET = 32'h0100_0000;
   localparam logic [31:0] NORM_SCALE_RESET = 32'h0001_0000;

   typedef struct packed {
      logic               func;
      logic [31:0]        pos_x;
      logic [31:0]        pos_y;
      logic [31:0]        pos_z;
      logic signed [23:0] particle_weight;
      logic [14:0]        cell_index;
   } pgd_req_type;

   typedef struct packed {
      logic signed [47:0] cell_value;
      logic               saturated;
   } pgd_rsp_type;

   typedef struct packed {
      logic                        func;
      logic [14:0]                 cell_index;
      logic signed [23:0]          particle_weight;
      logic [2:0][AXIS_W-1:0]      base;
      logic [2:0][3:0][23:0]       weight;
   } pgd_task_type;

   function automatic logic [23:0] div6(input logic [29:0] y);
      logic [60:0] p;
      p = 61'(y[29:1]) * 61'(32'hAAAA_AAAB);
      return 24'(p >> 33);
   endfunction

endpackage

// File: rtl/pgd_queue.sv
module pgd_queue
   import pgd_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         push,
   input  pgd_task_type push_data,
   output logic         full,
   input  logic         pop,
   output pgd_task_type head,
   output logic         empty
);

   pgd_task_type entry_ff [2];
   logic         wr_ptr_ff, wr_ptr_in;
   logic         rd_ptr_ff, rd_ptr_in;
   logic [1:0]   count_ff, count_in;

   assign full  = (count_ff == 2'd2);
   assign empty = (count_ff == 2'd0);
   assign head  = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ push;
      rd_ptr_in = rd_ptr_ff ^ pop;
      count_in  = count_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// File: rtl/pgd_front.sv
module pgd_front
   import pgd_pkg::*;
#(
   parameter int GRID_SIZE = 32
)
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  pgd_req_type        req_data,
   input  logic [31:0]        grid_scale,
   input  logic signed [23:0] offset_x,
   input  logic signed [23:0] offset_y,
   input  logic signed [23:0] offset_z,
   input  logic               hold,
   input  logic               q_full,
   output logic               q_push,
   output pgd_task_type       q_data
);

   localparam int CW = $clog2(GRID_SIZE);
   localparam int QW = 30;
   localparam int RS = QW + CW;
   localparam int STEP_W = 6;
   localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(5);
   localparam logic [QW-1:0] Q_BIAS = QW'(128 * GRID_SIZE);
   localparam logic [QW+1:0] RECIP = (QW+2)'((64'd1 << RS) / 64'(GRID_SIZE) + 64'd1);
   localparam logic [1:0] F_IDLE = 2'd0;
   localparam logic [1:0] F_CALC = 2'd1;
   localparam logic [1:0] F_PUSH = 2'd2;

   logic [1:0]        state_ff, state_in;
   logic [STEP_W-1:0] step_ff, step_in;
   pgd_req_type       req_ff;
   logic              acc;

   logic [63:0]       prod_ff [3];
   logic [23:0]       t_ff    [3];
   logic [24:0]       u_ff    [3];
   logic [23:0]       t2_ff   [3];
   logic [24:0]       u2_ff   [3];
   logic [23:0]       t3_ff   [3];
   logic [24:0]       u3_ff   [3];
   logic [29:0]       a1_ff   [3];
   logic [29:0]       a2_ff   [3];
   logic [3:0][23:0]  w_ff    [3];
   logic [QW-1:0]     sh_ff   [3];
   logic [QW-1:0]     quo_ff  [3];
   logic [CW-1:0]     rem_ff  [3];

   logic [31:0]        pos   [3];
   logic signed [23:0] off   [3];
   logic [53:0]        x     [3];

   assign req_stall = (state_ff != F_IDLE) || hold;
   assign acc       = req_valid && !req_stall;
   assign q_push    = (state_ff == F_PUSH) && !q_full;

   always_comb begin
      pos[0] = req_ff.pos_x;
      pos[1] = req_ff.pos_y;
      pos[2] = req_ff.pos_z;
      off[0] = offset_x;
      off[1] = offset_y;
      off[2] = offset_z;
      for (int a = 0; a < 3; a++) begin
         x[a] = {2'b00, prod_ff[a][63:12]} - {{22{off[a][23]}}, off[a], 8'h00};
      end
   end

   always_comb begin
      q_data.func            = req_ff.func;
      q_data.cell_index      = req_ff.cell_index;
      q_data.particle_weight = req_ff.particle_weight;
      for (int a = 0; a < 3; a++) begin
         q_data.base[a]   = AXIS_W'(rem_ff[a]);
         q_data.weight[a] = w_ff[a];
      end
   end

   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      unique case (state_ff)
         F_IDLE: begin
            if (acc) begin
               step_in  = '0;
               state_in = (req_data.func == FUNC_READ) ? F_PUSH : F_CALC;
            end
         end
         F_CALC: begin
            step_in = step_ff + 1'b1;
            if (step_ff == LAST_STEP) begin
               state_in = F_PUSH;
            end
         end
         F_PUSH: begin
            if (!q_full) begin
               state_in = F_IDLE;
            end
         end
         default: state_in = F_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_IDLE;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      if (acc) begin
         req_ff <= req_data;
      end
      for (int a = 0; a < 3; a++) begin
         if (state_ff == F_CALC) begin
            if (step_ff == 0) begin
               prod_ff[a] <= 64'(pos[a]) * 64'(grid_scale);
            end
            if (step_ff == 1) begin
               t_ff[a]   <= x[a][23:0];
               u_ff[a]   <= 25'(Q24) - {1'b0, x[a][23:0]};
               sh_ff[a]  <= x[a][53:24] + Q_BIAS;
            end
            if (step_ff == 2) begin
               t2_ff[a]  <= 24'((48'(t_ff[a]) * 48'(t_ff[a])) >> 24);
               u2_ff[a]  <= 25'((50'(u_ff[a]) * 50'(u_ff[a])) >> 24);
               quo_ff[a] <= QW'((64'(sh_ff[a]) * 64'(RECIP)) >> RS);
            end
            if (step_ff == 3) begin
               t3_ff[a]  <= 24'((48'(t2_ff[a]) * 48'(t_ff[a])) >> 24);
               u3_ff[a]  <= 25'((50'(u2_ff[a]) * 50'(u_ff[a])) >> 24);
               rem_ff[a] <= CW'(sh_ff[a] - QW'(quo_ff[a] * QW'(GRID_SIZE)));
            end
            if (step_ff == 4) begin
               a1_ff[a] <= 30'(4 * Q24) + 30'(3) * 30'(t3_ff[a]) - 30'(6) * 30'(t2_ff[a]);
               a2_ff[a] <= 30'(Q24) + 30'(3) * 30'(t_ff[a]) + 30'(3) * 30'(t2_ff[a])
                           - 30'(3) * 30'(t3_ff[a]);
            end
            if (step_ff == 5) begin
               w_ff[a][0] <= div6(30'(u3_ff[a]));
               w_ff[a][1] <= a1_ff[a][29] ? 24'd0 : div6(a1_ff[a]);
               w_ff[a][2] <= a2_ff[a][29] ? 24'd0 : div6(a2_ff[a]);
               w_ff[a][3] <= div6(30'(t3_ff[a]));
            end
         end
      end
   end

endmodule

// File: rtl/pgd_back.sv
module pgd_back
   import pgd_pkg::*;
#(
   parameter int GRID_SIZE = 32
)
(
   input  logic         clock,
   input  logic         reset,
   input  pgd_task_type q_head,
   input  logic         q_empty,
   output logic         q_pop,
   input  logic [31:0]  norm_scale,
   output logic         clear_busy,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output pgd_rsp_type  rsp_data
);

   localparam int CW = $clog2(GRID_SIZE);
   localparam int NUM_CELLS = GRID_SIZE * GRID_SIZE * GRID_SIZE;
   localparam int AW = $clog2(NUM_CELLS);
   localparam logic [2:0] B_IDLE  = 3'd0;
   localparam logic [2:0] B_DEP   = 3'd1;
   localparam logic [2:0] B_DRAIN = 3'd2;
   localparam logic [2:0] B_RD0   = 3'd3;
   localparam logic [2:0] B_RD1   = 3'd4;
   localparam logic [2:0] B_RD2   = 3'd5;
   localparam logic signed [49:0] CELL_MAX_50 = 50'sd140737488355327;
   localparam logic signed [49:0] CELL_MIN_50 = -50'sd140737488355328;
   localparam logic [64:0] LIM_POS = 65'h7FFF_FFFF_FFFF;
   localparam logic [64:0] LIM_NEG = 65'h8000_0000_0000;

   function automatic logic [CW-1:0] stencil_idx(input logic [AXIS_W-1:0] base,
                                                 input logic [1:0] o);
      logic [CW+1:0] s;
      s = (CW+2)'(base) + (CW+2)'(o) + (CW+2)'(GRID_SIZE - 1);
      if (s >= (CW+2)'(2 * GRID_SIZE)) begin
         s = s - (CW+2)'(2 * GRID_SIZE);
      end else if (s >= (CW+2)'(GRID_SIZE)) begin
         s = s - (CW+2)'(GRID_SIZE);
      end
      return CW'(s);
   endfunction

   logic [48:0] mem [NUM_CELLS];

   logic [2:0]         state_ff, state_in;
   logic [5:0]         cnt_ff, cnt_in;
   pgd_task_type       cur_ff;
   logic               clear_busy_ff;
   logic [AW-1:0]      clr_addr_ff;

   logic               v1_ff, v2_ff, v3_ff, v4_ff;
   logic [23:0]        wxy1_ff, wz1_ff, w2_ff;
   logic [AW-1:0]      addr1_ff, addr2_ff, addr3_ff, addr4_ff;
   logic signed [32:0] c3_ff, c4_ff;
   logic [48:0]        rdata_ff;

   logic               oor_ff, neg_ff, flag_ff;
   logic [63:0]        phi_ff, plo_ff;
   logic               rsp_valid_ff;
   pgd_rsp_type        rsp_data_ff;

   logic [CW-1:0]      ix, iy, iz;
   logic [AW-1:0]      addr_s1;
   logic [AW-1:0]      rd_addr;
   logic [AW-1:0]      rd_cell;
   logic signed [48:0] pw_prod;
   logic signed [49:0] sum;
   logic [47:0]        new_val;
   logic               ovf;
   logic [47:0]        mag;
   logic [64:0]        r;
   logic [64:0]        rmag;
   logic               clip;
   logic [47:0]        res;
   logic               we;
   logic [AW-1:0]      wa;
   logic [48:0]        wd;

   assign clear_busy = clear_busy_ff;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_data   = rsp_data_ff;
   assign rd_cell    = AW'(cur_ff.cell_index);

   assign q_pop = (state_ff == B_IDLE) && !clear_busy_ff && !q_empty
                  && ((q_head.func == FUNC_DEPOSIT) || !rsp_valid_ff);

   always_comb begin
      ix = stencil_idx(cur_ff.base[0], cnt_ff[5:4]);
      iy = stencil_idx(cur_ff.base[1], cnt_ff[3:2]);
      iz = stencil_idx(cur_ff.base[2], cnt_ff[1:0]);
      addr_s1 = AW'((32'(ix) * 32'(GRID_SIZE) + 32'(iy)) * 32'(GRID_SIZE) + 32'(iz));
      pw_prod = $signed({1'b0, w2_ff}) * cur_ff.particle_weight;
      sum = {{2{rdata_ff[47]}}, rdata_ff[47:0]} + {{17{c4_ff[32]}}, c4_ff};
      ovf = 1'b0;
      if (sum > CELL_MAX_50) begin
         new_val = 48'h7FFF_FFFF_FFFF;
         ovf     = 1'b1;
      end else if (sum < CELL_MIN_50) begin
         new_val = 48'h8000_0000_0000;
         ovf     = 1'b1;
      end else begin
         new_val = sum[47:0];
      end
      mag  = rdata_ff[47] ? (48'd0 - rdata_ff[47:0]) : rdata_ff[47:0];
      r    = 65'(phi_ff) + 65'(plo_ff >> 16);
      clip = 1'b0;
      if (!neg_ff && (r > LIM_POS)) begin
         rmag = LIM_POS;
         clip = 1'b1;
      end else if (neg_ff && (r > LIM_NEG)) begin
         rmag = LIM_NEG;
         clip = 1'b1;
      end else begin
         rmag = r;
      end
      res = neg_ff ? (48'd0 - rmag[47:0]) : rmag[47:0];
      rd_addr = (state_ff == B_RD0) ? rd_cell : addr3_ff;
   end

   always_comb begin
      we = 1'b0;
      wa = clr_addr_ff;
      wd = '0;
      priority if (clear_busy_ff) begin
         we = 1'b1;
      end else if (v4_ff) begin
         we = 1'b1;
         wa = addr4_ff;
         wd = {rdata_ff[48] | ovf, new_val};
      end else if ((state_ff == B_RD1) && !oor_ff) begin
         we = 1'b1;
         wa = rd_cell;
      end
   end

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      unique case (state_ff)
         B_IDLE: begin
            if (q_pop) begin
               cnt_in   = '0;
               state_in = (q_head.func == FUNC_DEPOSIT) ? B_DEP : B_RD0;
            end
         end
         B_DEP: begin
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == 6'd63) begin
               state_in = B_DRAIN;
            end
         end
         B_DRAIN: begin
            if (!v1_ff && !v2_ff && !v3_ff && !v4_ff) begin
               state_in = B_IDLE;
            end
         end
         B_RD0: state_in = B_RD1;
         B_RD1: state_in = B_RD2;
         B_RD2: state_in = B_IDLE;
         default: state_in = B_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= B_IDLE;
         cnt_ff        <= '0;
         clear_busy_ff <= 1'b1;
         clr_addr_ff   <= '0;
         v1_ff         <= 1'b0;
         v2_ff         <= 1'b0;
         v3_ff         <= 1'b0;
         v4_ff         <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         if (clear_busy_ff) begin
            clr_addr_ff <= clr_addr_ff + 1'b1;
            if (clr_addr_ff == AW'(NUM_CELLS - 1)) begin
               clear_busy_ff <= 1'b0;
            end
         end
         v1_ff <= (state_ff == B_DEP);
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
         if (state_ff == B_RD2) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         cur_ff <= q_head;
      end
      wxy1_ff  <= 24'((48'(cur_ff.weight[0][cnt_ff[5:4]])
                      * 48'(cur_ff.weight[1][cnt_ff[3:2]])) >> 24);
      wz1_ff   <= cur_ff.weight[2][cnt_ff[1:0]];
      addr1_ff <= addr_s1;
      w2_ff    <= 24'((48'(wxy1_ff) * 48'(wz1_ff)) >> 24);
      addr2_ff <= addr1_ff;
      c3_ff    <= pw_prod[48:16];
      addr3_ff <= addr2_ff;
      c4_ff    <= c3_ff;
      addr4_ff <= addr3_ff;
      if (state_ff == B_RD0) begin
         oor_ff <= (32'(cur_ff.cell_index) >= 32'(NUM_CELLS));
      end
      if (state_ff == B_RD1) begin
         neg_ff  <= rdata_ff[47];
         flag_ff <= rdata_ff[48];
         phi_ff  <= 64'(mag) * 64'(norm_scale[31:16]);
         plo_ff  <= 64'(mag) * 64'(norm_scale[15:0]);
      end
      if (state_ff == B_RD2) begin
         rsp_data_ff.cell_value <= oor_ff ? 48'sd0 : $signed(res);
         rsp_data_ff.saturated  <= oor_ff ? 1'b0 : (flag_ff | clip);
      end
   end

   always_ff @(posedge clock) begin
      rdata_ff <= mem[rd_addr];
      if (we) begin
         mem[wa] <= wd;
      end
   end

   a_rsp_free: assert property (@(posedge clock) disable iff (reset)
      (state_ff == B_RD2) |-> !rsp_valid_ff)
      else $error("result register loaded while a transaction is pending");

   a_clear_quiet: assert property (@(posedge clock) disable iff (reset)
      clear_busy_ff |-> (!q_pop && !v4_ff && (state_ff == B_IDLE)))
      else $error("cell update during clearing pass");

   a_idle_drained: assert property (@(posedge clock) disable iff (reset)
      (state_ff == B_IDLE) |-> !(v1_ff || v2_ff || v3_ff || v4_ff))
      else $error("idle with stencil updates in flight");

endmodule

// File: rtl/pcs_particle_grid_deposit.sv
// Cubic-spline particle deposit onto a periodic GRID_SIZE^3 grid. A deposit transaction
// is taken by the front end through its calculation steps (one 32x32 scaling multiply,
// spline powers, and a reciprocal multiplication that reduces each cell coordinate modulo
// GRID_SIZE), and its 64 stencil updates then run at one read-modify-write per cycle on the
// single write port of the cell memory, followed by a drain of the update pipeline, with
// the front end preparing the next deposit in parallel through a two-entry queue. A
// read-and-clear transaction runs through the read states of the back end and waits only
// for the result register to be free. After reset a clearing pass writes every cell once,
// one per cycle, and req_stall stays high until it ends; configuration writes are taken at
// any time.
module pcs_particle_grid_deposit
   import pgd_pkg::*;
#(
   parameter int GRID_SIZE = 32
)
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  pgd_req_type          req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output pgd_rsp_type          rsp_data,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [31:0]          csr_wdata
);

   logic [31:0]        grid_scale_ff;
   logic signed [23:0] offset_x_ff;
   logic signed [23:0] offset_y_ff;
   logic signed [23:0] offset_z_ff;
   logic [31:0]        norm_scale_ff;

   logic               clear_busy;
   logic               q_full, q_push, q_pop, q_empty;
   pgd_task_type       q_in, q_head;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         grid_scale_ff <= GRID_SCALE_RESET;
         offset_x_ff   <= '0;
         offset_y_ff   <= '0;
         offset_z_ff   <= '0;
         norm_scale_ff <= NORM_SCALE_RESET;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_GRID_SCALE: grid_scale_ff <= csr_wdata;
            CSR_OFFSET_X:   offset_x_ff   <= csr_wdata[23:0];
            CSR_OFFSET_Y:   offset_y_ff   <= csr_wdata[23:0];
            CSR_OFFSET_Z:   offset_z_ff   <= csr_wdata[23:0];
            CSR_NORM_SCALE: norm_scale_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   pgd_front #(
      .GRID_SIZE(GRID_SIZE)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_data   (req_data),
      .grid_scale (grid_scale_ff),
      .offset_x   (offset_x_ff),
      .offset_y   (offset_y_ff),
      .offset_z   (offset_z_ff),
      .hold       (clear_busy),
      .q_full     (q_full),
      .q_push     (q_push),
      .q_data     (q_in)
   );

   pgd_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_in),
      .full      (q_full),
      .pop       (q_pop),
      .head      (q_head),
      .empty     (q_empty)
   );

   pgd_back #(
      .GRID_SIZE(GRID_SIZE)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .q_head     (q_head),
      .q_empty    (q_empty),
      .q_pop      (q_pop),
      .norm_scale (norm_scale_ff),
      .clear_busy (clear_busy),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_data   (rsp_data)
   );

endmodule

// File: test/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
   import pgd_pkg::*;

   localparam int GRID = 32;
   localparam int NCELLS = GRID * GRID * GRID;
   localparam longint CELL_HI = 64'sd140737488355327;
   localparam longint CELL_LO = -64'sd140737488355328;
   localparam int DRAIN_CYCLES = 400;
   localparam int LONG_HOLD = 3000;
   localparam longint CYCLE_LIMIT = 3000000;

   logic                 clock;
   logic                 reset;
   logic                 req_valid;
   logic                 req_stall;
   pgd_req_type          req_data;
   logic                 rsp_valid;
   logic                 rsp_stall;
   pgd_rsp_type          rsp_data;
   logic                 csr_valid;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [31:0]          csr_wdata;

   pcs_particle_grid_deposit #(.GRID_SIZE(GRID)) uut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   longint      cell_mass [NCELLS];
   bit          cell_clipped [NCELLS];
   logic [31:0] sh_grid_scale;
   int          sh_offset [3];
   logic [31:0] sh_norm_scale;

   pgd_req_type pending_items[$];
   pgd_rsp_type expected_cells[$];
   bit          idle_enable;
   bit          start_hold;
   bit          hold_taken;
   bit          failed;
   int          gap_left;
   int          stall_left;
   int          hold_left;
   longint      cycle_count;
   int          hot_pos_max;

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   function automatic void spline_axis(input logic [31:0] pos, input int off,
                                       output int idx[4], output longint unsigned w[4]);
      longint unsigned prod, t, u, t2, t3, u2, u3;
      longint x, r, a;
      prod = longint'(pos) * longint'(sh_grid_scale);
      x = longint'(prod >> 12) - longint'(off) * 256;
      t = x & 64'hFF_FFFF;
      r = (x >>> 24) & (GRID - 1);
      idx[0] = int'((r + GRID - 1) % GRID);
      idx[1] = int'(r);
      idx[2] = int'((r + 1) % GRID);
      idx[3] = int'((r + 2) % GRID);
      u = 64'd16777216 - t;
      t2 = (t * t) >> 24;
      t3 = (t2 * t) >> 24;
      u2 = (u * u) >> 24;
      u3 = (u2 * u) >> 24;
      w[0] = u3 / 6;
      a = 4 * 64'sd16777216 + 3 * longint'(t3) - 6 * longint'(t2);
      w[1] = a > 0 ? longint'(a) / 6 : 0;
      a = 64'sd16777216 + 3 * longint'(t) + 3 * longint'(t2) - 3 * longint'(t3);
      w[2] = a > 0 ? longint'(a) / 6 : 0;
      w[3] = t3 / 6;
   endfunction

   function automatic void deposit_particle(input pgd_req_type it);
      int ix[4], iy[4], iz[4];
      longint unsigned wx[4], wy[4], wz[4];
      longint unsigned wxy, w;
      longint pw, c, s;
      int cell_idx;
      spline_axis(it.pos_x, sh_offset[0], ix, wx);
      spline_axis(it.pos_y, sh_offset[1], iy, wy);
      spline_axis(it.pos_z, sh_offset[2], iz, wz);
      pw = longint'(it.particle_weight);
      for (int i = 0; i < 4; i++)
         for (int j = 0; j < 4; j++) begin
            wxy = (wx[i] * wy[j]) >> 24;
            for (int k = 0; k < 4; k++) begin
               w = (wxy * wz[k]) >> 24;
               c = (longint'(w) * pw) >>> 16;
               cell_idx = (ix[i] * GRID + iy[j]) * GRID + iz[k];
               s = cell_mass[cell_idx] + c;
               if (s > CELL_HI) begin
                  s = CELL_HI;
                  cell_clipped[cell_idx] = 1'b1;
               end else if (s < CELL_LO) begin
                  s = CELL_LO;
                  cell_clipped[cell_idx] = 1'b1;
               end
               cell_mass[cell_idx] = s;
            end
         end
   endfunction

   function automatic pgd_rsp_type read_cell(input logic [14:0] index);
      pgd_rsp_type res;
      longint v;
      longint unsigned mag, r;
      bit neg, clip;
      res = '0;
      if (int'(index) < NCELLS) begin
         v = cell_mass[index];
         neg = v < 0;
         clip = 1'b0;
         mag = neg ? longint'(-v) : longint'(v);
         r = mag * longint'(sh_norm_scale[31:16])
             + ((mag * longint'(sh_norm_scale[15:0])) >> 16);
         if (!neg && r > longint'(CELL_HI)) begin
            r = CELL_HI;
            clip = 1'b1;
         end else if (neg && r > longint'(CELL_HI) + 1) begin
            r = longint'(CELL_HI) + 1;
            clip = 1'b1;
         end
         res.cell_value = neg ? 48'(-longint'(r)) : 48'(r);
         res.saturated = cell_clipped[index] | clip;
         cell_mass[index] = 0;
         cell_clipped[index] = 1'b0;
      end
      return res;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         req_data <= '0;
         gap_left = 0;
      end else begin
         if (req_valid && !req_stall) begin
            if (req_data.func == FUNC_DEPOSIT) deposit_particle(req_data);
            else expected_cells.push_back(read_cell(req_data.cell_index));
         end
         if (!req_valid || !req_stall) begin
            if (gap_left > 0) begin
               gap_left--;
               req_valid <= 1'b0;
            end else if (pending_items.size() > 0) begin
               if (idle_enable && $urandom_range(0, 9) == 0) begin
                  gap_left = $urandom_range(0, 15);
                  req_valid <= 1'b0;
               end else begin
                  req_data <= pending_items.pop_front();
                  req_valid <= 1'b1;
               end
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      pgd_rsp_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
         stall_left = 0;
         hold_left = 0;
         hold_taken = 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_cells.size() == 0) begin
               $display("%0t: unexpected result, actual %h/%0b", $time,
                        rsp_data.cell_value, rsp_data.saturated);
               failed = 1'b1;
            end else begin
               want = expected_cells.pop_front();
               if (rsp_data.cell_value !== want.cell_value) begin
                  $display("%0t: cell_value expected %0d actual %0d", $time,
                           want.cell_value, rsp_data.cell_value);
                  failed = 1'b1;
               end
               if (rsp_data.saturated !== want.saturated) begin
                  $display("%0t: saturated expected %0b actual %0b", $time,
                           want.saturated, rsp_data.saturated);
                  failed = 1'b1;
               end
            end
         end
         if (start_hold && !hold_taken) begin
            hold_taken = 1'b1;
            hold_left = LONG_HOLD;
         end
         if (hold_left > 0) hold_left--;
         if (stall_left > 0) stall_left--;
         else if (idle_enable && $urandom_range(0, 7) == 0) stall_left = $urandom_range(1, 16);
         rsp_stall <= (hold_left > 0) || (stall_left > 0);
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end
   end

   task automatic csr_write(input logic [CSR_IDX_W-1:0] idx, input logic [31:0] val);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      case (idx)
         CSR_GRID_SCALE: sh_grid_scale = val;
         CSR_OFFSET_X:   sh_offset[0] = int'(signed'(val[23:0]));
         CSR_OFFSET_Y:   sh_offset[1] = int'(signed'(val[23:0]));
         CSR_OFFSET_Z:   sh_offset[2] = int'(signed'(val[23:0]));
         CSR_NORM_SCALE: sh_norm_scale = val;
         default: ;
      endcase
   endtask

   task automatic set_grid(input logic [31:0] gs, input logic [23:0] ox, input logic [23:0] oy,
                           input logic [23:0] oz, input logic [31:0] ns);
      csr_write(CSR_GRID_SCALE, gs);
      csr_write(CSR_OFFSET_X, 32'(ox));
      csr_write(CSR_OFFSET_Y, 32'(oy));
      csr_write(CSR_OFFSET_Z, 32'(oz));
      csr_write(CSR_NORM_SCALE, ns);
   endtask

   task automatic wait_quiet();
      while (pending_items.size() > 0 || req_valid || expected_cells.size() > 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   function automatic pgd_req_type noise_item();
      pgd_req_type it;
      it.func = 1'($urandom);
      it.pos_x = $urandom;
      it.pos_y = $urandom;
      it.pos_z = $urandom;
      it.particle_weight = 24'($urandom);
      it.cell_index = 15'($urandom);
      return it;
   endfunction

   function automatic int hot_axis();
      int v;
      v = $urandom_range(0, 9);
      return v > 7 ? v + 22 : v;
   endfunction

   function automatic pgd_req_type random_item();
      pgd_req_type it;
      it = noise_item();
      if ($urandom_range(0, 4) < 2) begin
         it.func = FUNC_READ;
         if ($urandom_range(0, 4) != 0)
            it.cell_index = 15'((hot_axis() * GRID + hot_axis()) * GRID + hot_axis());
      end else begin
         it.func = FUNC_DEPOSIT;
         if ($urandom_range(0, 4) != 0) begin
            it.pos_x = $urandom_range(0, hot_pos_max);
            it.pos_y = $urandom_range(0, hot_pos_max);
            it.pos_z = $urandom_range(0, hot_pos_max);
            if ($urandom_range(0, 1) == 0) it.particle_weight = 24'sd65536;
            else it.particle_weight = -24'($urandom_range(0, 65536));
         end
      end
      return it;
   endfunction

   task automatic add_item(input logic f, input logic [31:0] p, input logic [23:0] w,
                           input logic [14:0] c);
      pgd_req_type it;
      it = noise_item();
      it.func = f;
      if (f == FUNC_DEPOSIT) begin
         it.pos_x = p;
         it.pos_y = p;
         it.pos_z = p;
         it.particle_weight = w;
      end else begin
         it.cell_index = c;
      end
      pending_items.push_back(it);
   endtask

   task automatic add_random(input int count);
      for (int n = 0; n < count; n++) pending_items.push_back(random_item());
   endtask

   initial begin
      start_hold = 1'b0;
      idle_enable = 1'b1;
      hot_pos_max = 8 * 4096 - 1;
      csr_valid = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      for (int i = 0; i < NCELLS; i++) begin
         cell_mass[i] = 0;
         cell_clipped[i] = 1'b0;
      end
      sh_grid_scale = GRID_SCALE_RESET;
      sh_offset = '{0, 0, 0};
      sh_norm_scale = NORM_SCALE_RESET;
      reset = 1'b1;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      add_item(FUNC_READ, '0, '0, 15'd0);
      add_item(FUNC_READ, '0, '0, 15'd32767);
      add_item(FUNC_DEPOSIT, 32'd0, 24'sd65536, '0);
      add_item(FUNC_DEPOSIT, 32'hFFFF_FFFF, 24'h7F_FFFF, '0);
      add_item(FUNC_DEPOSIT, 32'h0000_0800, 24'h80_0000, '0);
      add_item(FUNC_DEPOSIT, 32'h0000_1000, 24'd0, '0);
      add_item(FUNC_DEPOSIT, 32'h0000_0001, 24'hFF_FFFF, '0);
      add_item(FUNC_DEPOSIT, 32'h0000_0FFF, 24'h7F_FFFF, '0);
      add_item(FUNC_READ, '0, '0, 15'd0);
      add_item(FUNC_READ, '0, '0, 15'd0);
      add_item(FUNC_READ, '0, '0, 15'd1);
      add_item(FUNC_READ, '0, '0, 15'd33);
      add_item(FUNC_READ, '0, '0, 15'd1057);
      add_item(FUNC_READ, '0, '0, 15'd2114);
      add_item(FUNC_READ, '0, '0, 15'd31);
      add_item(FUNC_READ, '0, '0, 15'd32767);
      add_item(FUNC_READ, '0, '0, 15'd31744);
      add_item(FUNC_READ, '0, '0, 15'd1023);
      wait_quiet();

      hot_pos_max = 8 * 4096 / 32 - 1;
      set_grid(32'h2000_0000, 24'($urandom_range(0, 65535)), 24'($urandom_range(0, 65535)),
               24'($urandom_range(0, 65535)), $urandom_range(32768, 262144));
      add_random(500);
      wait_quiet();

      add_random(60);
      start_hold = 1'b1;
      wait_quiet();

      set_grid(32'hFFFF_FFFF, 24'h7F_FFFF, 24'h80_0000, 24'd0, 32'd0);
      add_random(150);
      wait_quiet();

      hot_pos_max = 8 * 4096 - 1;
      set_grid(32'd0, 24'h80_0000, 24'h7F_FFFF, 24'h12_3456, 32'hFFFF_FFFF);
      add_random(100);
      wait_quiet();

      set_grid(GRID_SCALE_RESET, 24'd0, 24'd0, 24'd0, 32'hFFFF_FFFF);
      for (int n = 0; n < 6; n++) add_item(FUNC_DEPOSIT, 32'h0000_5000, 24'h7F_FFFF, '0);
      for (int n = 0; n < 6; n++) add_item(FUNC_DEPOSIT, 32'h0000_9000, 24'h80_0000, '0);
      add_item(FUNC_READ, '0, '0, 15'((5 * GRID + 5) * GRID + 5));
      add_item(FUNC_READ, '0, '0, 15'((9 * GRID + 9) * GRID + 9));
      add_item(FUNC_READ, '0, '0, 15'((4 * GRID + 4) * GRID + 4));
      wait_quiet();

      set_grid(GRID_SCALE_RESET, 24'($urandom_range(0, 255)), 24'd0,
               24'($urandom_range(0, 255)), NORM_SCALE_RESET);
      add_random(400);
      wait_quiet();

      idle_enable = 1'b0;
      add_random(420);
      wait_quiet();

      if (!failed) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
